[hw/rtl/prm_pkg.sv]
// Shared constants, types and the power-up colour table of the pseudocolour ramp mapper.
// Depends on nothing; the mapper unit uses it by scoped names.
package prm_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int TABLE_ENTRIES = 12;
    localparam int BG_INDEX      = TABLE_ENTRIES - 1;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // ramp value V holds 0..10 with FRACTION_BITS fraction bits
    localparam int V_W   = FRACTION_BITS + 4;
    // V plus a rounding offset, and the integer part of that sum
    localparam int VS_W  = V_W + 1;
    localparam int IR_W  = VS_W - FRACTION_BITS;
    localparam int REM_W = FRACTION_BITS + 1;
    localparam int MIX_W = REM_W + 8 + 1;

    localparam logic [VS_W-1:0] OFS_001 =
        VS_W'(((1 << FRACTION_BITS) + 50) / 100);
    localparam logic [VS_W-1:0] OFS_051 =
        VS_W'((51 * (1 << FRACTION_BITS) + 50) / 100);
    localparam logic [REM_W-1:0] ONE_FX = REM_W'(1) << FRACTION_BITS;
    localparam logic [63:0] RAMP_LIMIT = 64'd10 << (2 * FRACTION_BITS);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(BG_INDEX - 1);
    localparam logic [IDX_W-1:0] IDX_BG  = IDX_W'(BG_INDEX);
    localparam logic [IDX_W-1:0] IDX_WHITE = '0;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSTHROUGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_VALUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_SCALE = 3'd5;

    localparam logic [31:0] DOMAIN_SCALE_RST = 32'd10 << FRACTION_BITS;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    function automatic t_rgb default_entry(input logic [IDX_W-1:0] idx);
        t_rgb e;
        case (idx)
            4'd0:    e = '{8'd255, 8'd255, 8'd255};
            4'd1:    e = '{8'd100, 8'd100, 8'd140};
            4'd2:    e = '{8'd0,   8'd0,   8'd255};
            4'd3:    e = '{8'd0,   8'd120, 8'd255};
            4'd4:    e = '{8'd100, 8'd200, 8'd140};
            4'd5:    e = '{8'd0,   8'd150, 8'd0};
            4'd6:    e = '{8'd0,   8'd225, 8'd0};
            4'd7:    e = '{8'd255, 8'd255, 8'd0};
            4'd8:    e = '{8'd255, 8'd160, 8'd0};
            4'd9:    e = '{8'd255, 8'd100, 8'd100};
            4'd10:   e = '{8'd255, 8'd0,   8'd0};
            default: e = '{8'd0,   8'd0,   8'd0};
        endcase
        return e;
    endfunction

endpackage

[hw/rtl/pseudocolor_ramp_mapper_unit.sv]
// Pseudocolour ramp mapper: five-stage pipeline from scalar sample to RGB pixel.
// Depends on prm_pkg for constants, the pixel type and the power-up colour table.
//
// Use:
//   Input channel (i_valid / o_stall): each transfer carries a command. cmd 0 maps
//   i_sample to a pixel; cmd 1 writes one colour table entry and gives no result.
//   Output channel (o_valid / i_stall): one pixel per map command, in order.
//   Configuration channel (i_cfg_valid / o_cfg_ready): always ready; write only
//   while the pipeline holds no item.
// Timing:
//   An item transfers in every cycle while o_stall is low. A map result passes
//   through the stage chain: offset, 32x32 scale multiply, range test and index,
//   two-port table read, blend.
//   A table write lands at the table-read stage, so it orders exactly against
//   the maps around it.
// Stall:
//   i_stall holds the output register; bubbles ahead of it still fill, then
//   o_stall rises. Nothing is lost or repeated.
// Reset:
//   Clears all stage valids and the registers to their defaults; the colour
//   table reads its power-up ramp until each entry is written.
module pseudocolor_ramp_mapper_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [prm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic signed [31:0]            i_sample,
    input  logic [7:0]                    i_red_in,
    input  logic [7:0]                    i_green_in,
    input  logic [7:0]                    i_blue_in,
    input  logic [3:0]                    i_entry_index,
    input  logic [7:0]                    i_entry_red,
    input  logic [7:0]                    i_entry_green,
    input  logic [7:0]                    i_entry_blue,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_red_out,
    output logic [7:0]                    o_green_out,
    output logic [7:0]                    o_blue_out,
    output logic                          o_is_background
);

    localparam int F = prm_pkg::FRACTION_BITS;

    // ---------------- configuration registers ----------------
    logic               r_passthrough;
    logic               r_interpolate;
    logic               r_single_en;
    logic signed [31:0] r_single_value;
    logic signed [31:0] r_domain_low;
    logic [31:0]        r_domain_scale;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passthrough  <= 1'b0;
            r_interpolate  <= 1'b1;
            r_single_en    <= 1'b0;
            r_single_value <= '0;
            r_domain_low   <= '0;
            r_domain_scale <= prm_pkg::DOMAIN_SCALE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prm_pkg::CFG_PASSTHROUGH:  r_passthrough  <= i_cfg_data[0];
                prm_pkg::CFG_INTERPOLATE:  r_interpolate  <= i_cfg_data[0];
                prm_pkg::CFG_SINGLE_EN:    r_single_en    <= i_cfg_data[0];
                prm_pkg::CFG_SINGLE_VALUE: r_single_value <= i_cfg_data;
                prm_pkg::CFG_DOMAIN_LOW:   r_domain_low   <= i_cfg_data;
                prm_pkg::CFG_DOMAIN_SCALE: r_domain_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage registers ----------------
    // A: offset sample
    logic                r_a_vld, r_a_cmd, r_a_pass, r_a_bg;
    logic [31:0]         r_a_diff;
    prm_pkg::t_rgb       r_a_rgb, r_a_entry;
    logic [3:0]          r_a_eidx;
    // B: scaled product
    logic                r_b_vld, r_b_cmd, r_b_pass, r_b_bg;
    logic [63:0]         r_b_prod;
    prm_pkg::t_rgb       r_b_rgb, r_b_entry;
    logic [3:0]          r_b_eidx;
    // C: table addresses and blend weights
    logic                r_c_vld, r_c_cmd, r_c_pass, r_c_bg, r_c_blend;
    logic [prm_pkg::IDX_W-1:0] r_c_addr_a, r_c_addr_b;
    logic [prm_pkg::REM_W-1:0] r_c_rem, r_c_res;
    prm_pkg::t_rgb       r_c_rgb, r_c_entry;
    logic [3:0]          r_c_eidx;
    // D: table entries read
    logic                r_d_vld, r_d_cmd, r_d_pass, r_d_bg, r_d_blend;
    logic [prm_pkg::REM_W-1:0] r_d_rem, r_d_res;
    prm_pkg::t_rgb       r_d_rgb, r_d_ent_a, r_d_ent_b;
    // E: output register
    logic                r_e_vld, r_e_bg;
    prm_pkg::t_rgb       r_e_pix;

    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    // a stage loads when it is empty or its content moves on
    assign rdy_e = !r_e_vld || !i_stall;
    assign rdy_d = !r_d_vld || rdy_e;
    assign rdy_c = !r_c_vld || rdy_d;
    assign rdy_b = !r_b_vld || rdy_c;
    assign rdy_a = !r_a_vld || rdy_b;
    assign o_stall = !rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else begin
            if (rdy_a) r_a_vld <= i_valid;
            if (rdy_b) r_b_vld <= r_a_vld;
            if (rdy_c) r_c_vld <= r_b_vld;
            if (rdy_d) r_d_vld <= r_c_vld;
            // table writes end here with no result
            if (rdy_e) r_e_vld <= r_d_vld && !r_d_cmd;
        end
    end

    // ---------------- stage A ----------------
    logic [32:0] n_a_diff;
    logic        n_a_bg;

    always_comb begin
        n_a_diff = {i_sample[31], i_sample} - {r_domain_low[31], r_domain_low};
        // below the domain with a live scale, or the wrong value in single value mode
        n_a_bg   = (r_single_en && (i_sample != r_single_value))
                || (n_a_diff[32] && (r_domain_scale != '0));
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_cmd   <= i_cmd;
            r_a_pass  <= r_passthrough;
            r_a_bg    <= n_a_bg;
            r_a_diff  <= n_a_diff[31:0];
            r_a_rgb   <= '{i_red_in, i_green_in, i_blue_in};
            r_a_entry <= '{i_entry_red, i_entry_green, i_entry_blue};
            r_a_eidx  <= i_entry_index;
        end
    end

    // ---------------- stage B ----------------
    // a negative offset gives a zero product with zero scale; with a live scale it is already background
    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_cmd   <= r_a_cmd;
            r_b_pass  <= r_a_pass;
            r_b_bg    <= r_a_bg;
            r_b_prod  <= {32'd0, r_a_diff} * {32'd0, r_domain_scale};
            r_b_rgb   <= r_a_rgb;
            r_b_entry <= r_a_entry;
            r_b_eidx  <= r_a_eidx;
        end
    end

    // ---------------- stage C ----------------
    logic                         c_bg, c_zero;
    logic [prm_pkg::V_W-1:0]      c_v, c_idx_sh, c_rem_full;
    logic [prm_pkg::VS_W-1:0]     c_sum_i, c_sum_n;
    logic [prm_pkg::IR_W-1:0]     c_raw_i, c_raw_n;
    logic [prm_pkg::IDX_W-1:0]    c_idx_i, c_idx_n;
    logic [prm_pkg::REM_W-1:0]    c_rem;
    logic [prm_pkg::IDX_W-1:0]    n_c_addr_a;

    always_comb begin
        c_bg    = r_b_bg || (r_b_prod > prm_pkg::RAMP_LIMIT);
        c_zero  = (r_b_prod == '0);
        c_v     = r_b_prod[F +: prm_pkg::V_W];

        c_sum_i = {1'b0, c_v} + prm_pkg::OFS_001;
        c_sum_n = {1'b0, c_v} + prm_pkg::OFS_051;
        c_raw_i = c_sum_i[F +: prm_pkg::IR_W];
        c_raw_n = c_sum_n[F +: prm_pkg::IR_W];
        c_idx_i = (c_raw_i > prm_pkg::IR_W'(prm_pkg::IDX_TOP))
                ? prm_pkg::IDX_TOP : c_raw_i[prm_pkg::IDX_W-1:0];
        c_idx_n = (c_raw_n > prm_pkg::IR_W'(prm_pkg::IDX_TOP))
                ? prm_pkg::IDX_TOP : c_raw_n[prm_pkg::IDX_W-1:0];

        // fraction above the lower entry; a value rounded up gives none
        c_idx_sh   = {c_idx_i, {F{1'b0}}};
        c_rem_full = (c_v >= c_idx_sh) ? (c_v - c_idx_sh) : '0;
        c_rem      = (c_rem_full > prm_pkg::V_W'(prm_pkg::ONE_FX))
                   ? prm_pkg::ONE_FX : c_rem_full[prm_pkg::REM_W-1:0];

        if (c_bg) begin
            n_c_addr_a = prm_pkg::IDX_BG;
        end else if (c_zero) begin
            n_c_addr_a = prm_pkg::IDX_WHITE;
        end else if (r_interpolate) begin
            n_c_addr_a = c_idx_i;
        end else begin
            n_c_addr_a = c_idx_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_cmd    <= r_b_cmd;
            r_c_pass   <= r_b_pass;
            r_c_bg     <= c_bg;
            r_c_blend  <= r_interpolate && !c_bg && !c_zero;
            r_c_addr_a <= n_c_addr_a;
            r_c_addr_b <= c_idx_i + 1'b1;
            r_c_rem    <= c_rem;
            r_c_res    <= prm_pkg::ONE_FX - c_rem;
            r_c_rgb    <= r_b_rgb;
            r_c_entry  <= r_b_entry;
            r_c_eidx   <= r_b_eidx;
        end
    end

    // ---------------- colour table ----------------
    prm_pkg::t_rgb              r_mem [prm_pkg::TABLE_ENTRIES];
    logic [prm_pkg::TABLE_ENTRIES-1:0] r_mem_vld;
    logic                       c_wr_en;

    assign c_wr_en = r_c_vld && r_c_cmd && rdy_d
                  && (r_c_eidx < 4'(prm_pkg::TABLE_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (c_wr_en) begin
            r_mem_vld[r_c_eidx[prm_pkg::IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr_en) begin
            r_mem[r_c_eidx[prm_pkg::IDX_W-1:0]] <= r_c_entry;
        end
    end

    // ---------------- stage D: registered table reads ----------------
    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_d_ent_a <= r_mem_vld[r_c_addr_a] ? r_mem[r_c_addr_a]
                                               : prm_pkg::default_entry(r_c_addr_a);
            r_d_ent_b <= r_mem_vld[r_c_addr_b] ? r_mem[r_c_addr_b]
                                               : prm_pkg::default_entry(r_c_addr_b);
            r_d_cmd   <= r_c_cmd;
            r_d_pass  <= r_c_pass;
            r_d_bg    <= r_c_bg;
            r_d_blend <= r_c_blend;
            r_d_rem   <= r_c_rem;
            r_d_res   <= r_c_res;
            r_d_rgb   <= r_c_rgb;
        end
    end

    // ---------------- stage E: blend and output ----------------
    function automatic logic [7:0] blend_ch(
        input logic [prm_pkg::REM_W-1:0] res,
        input logic [prm_pkg::REM_W-1:0] rem,
        input logic [7:0]                a,
        input logic [7:0]                b
    );
        logic [prm_pkg::MIX_W-1:0] mix;
        mix = prm_pkg::MIX_W'(res) * prm_pkg::MIX_W'(a)
            + prm_pkg::MIX_W'(rem) * prm_pkg::MIX_W'(b);
        return mix[F +: 8];
    endfunction

    prm_pkg::t_rgb n_e_pix;
    logic          n_e_bg;

    always_comb begin
        if (r_d_pass) begin
            n_e_pix = r_d_rgb;
            n_e_bg  = 1'b0;
        end else if (r_d_blend) begin
            n_e_pix.red   = blend_ch(r_d_res, r_d_rem, r_d_ent_a.red,   r_d_ent_b.red);
            n_e_pix.green = blend_ch(r_d_res, r_d_rem, r_d_ent_a.green, r_d_ent_b.green);
            n_e_pix.blue  = blend_ch(r_d_res, r_d_rem, r_d_ent_a.blue,  r_d_ent_b.blue);
            n_e_bg        = 1'b0;
        end else begin
            n_e_pix = r_d_ent_a;
            n_e_bg  = r_d_bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_e) begin
            r_e_pix <= n_e_pix;
            r_e_bg  <= n_e_bg;
        end
    end

    assign o_valid         = r_e_vld;
    assign o_red_out       = r_e_pix.red;
    assign o_green_out     = r_e_pix.green;
    assign o_blue_out      = r_e_pix.blue;
    assign o_is_background = r_e_bg;

endmodule
